[rtl/blwe_pkg.sv]
// ----------------------------------------------------------------------------
// blwe_pkg
// Operation codes, status codes and the command and status bundles that pass
// between the list controller and the list datapath.
// ----------------------------------------------------------------------------
package blwe_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_ERASE = 2'd2,
    KIND_FIND  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;      // capture the search value and clear the index
    logic    push_wr;   // write the new value at the newest end
    logic    dec;       // drop one entry from the count
    logic    rd_en;     // read the entry memory
    logic    rd_next;   // read at index + 1 instead of index
    logic    idx_inc;   // advance the index
    logic    shift_wr;  // write the last read word at the index
    logic    hit;       // remember the index as the match position
    logic    report;    // register a result for the output strobe
    status_t status;
    logic    found;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_lt_cnt;
    logic nxt_lt_cnt;
    logic match;
  } dp_stat_t;

endpackage

[rtl/blwe_ctrl.sv]
// ----------------------------------------------------------------------------
// blwe_ctrl
// Sequencer for the list: handles push and pop at once, and steps find and
// erase through the entry memory one word at a time.
// ----------------------------------------------------------------------------
module blwe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  blwe_pkg::kind_t    in_kind,
  input  blwe_pkg::dp_stat_t stat,
  output blwe_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SCAN_RD  = 5'b00010,
    S_SCAN_CMP = 5'b00100,
    S_SHIFT_RD = 5'b01000,
    S_SHIFT_WR = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  blwe_pkg::kind_t kind_r, kind_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    cmd        = '0;
    cmd.status = blwe_pkg::ST_DONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt = in_kind;
          unique case (in_kind)
            blwe_pkg::KIND_PUSH: begin
              cmd.report = 1'b1;
              if (stat.full) begin
                cmd.status = blwe_pkg::ST_FULL;
              end else begin
                cmd.push_wr = 1'b1;
              end
            end
            blwe_pkg::KIND_POP: begin
              cmd.report = 1'b1;
              if (stat.empty) begin
                cmd.status = blwe_pkg::ST_EMPTY;
              end else begin
                cmd.dec = 1'b1;
              end
            end
            blwe_pkg::KIND_ERASE, blwe_pkg::KIND_FIND: begin
              cmd.load  = 1'b1;
              state_nxt = S_SCAN_RD;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (stat.idx_lt_cnt) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_SCAN_CMP;
        end else begin
          cmd.report = 1'b1;
          cmd.status = blwe_pkg::ST_MISSING;
          state_nxt  = S_IDLE;
        end
      end
      S_SCAN_CMP: begin
        if (stat.match) begin
          cmd.hit = 1'b1;
          if (kind_r == blwe_pkg::KIND_FIND) begin
            cmd.report = 1'b1;
            cmd.found  = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_SHIFT_RD;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        // The index walks from the match toward the newest entry, pulling
        // each later word down by one place.
        if (stat.nxt_lt_cnt) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_nxt   = S_SHIFT_WR;
        end else begin
          cmd.dec    = 1'b1;
          cmd.report = 1'b1;
          cmd.found  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= blwe_pkg::KIND_PUSH;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

[rtl/blwe_dpath.sv]
// ----------------------------------------------------------------------------
// blwe_dpath
// Entry memory, entry count, scan index and the registered result fields.
// ----------------------------------------------------------------------------
module blwe_dpath #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [31:0] in_value,
  input  blwe_pkg::dp_cmd_t  cmd,
  output blwe_pkg::dp_stat_t stat,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic [3:0]         out_match_position,
  output logic [4:0]         out_entry_count,
  output logic               out_is_empty
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [31:0]      mem [CAPACITY];
  logic [31:0]      rdata_r;
  logic [31:0]      value_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  // The index has the count's width so that a full scan can step past the
  // last entry without wrapping back to the oldest one.
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] idx_plus1;
  logic [IDX_W-1:0] pos_r;
  logic [IDX_W-1:0] pos_sel;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_data;
  logic             wr_en;
  logic [CNT_W-1:0] idx_w;
  logic [31:0]      pos_ext;
  logic [31:0]      cnt_ext;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic        out_found_r;
  logic [3:0]  out_pos_r;
  logic [4:0]  out_count_r;
  logic        out_empty_r;

  assign idx_w     = idx_r;
  assign idx_plus1 = idx_r + CNT_W'(1);

  assign stat.full       = (count_r >= CNT_W'(CAPACITY));
  assign stat.empty      = (count_r == '0);
  assign stat.idx_lt_cnt = (idx_w < count_r);
  assign stat.nxt_lt_cnt = (idx_plus1 < count_r);
  assign stat.match      = (rdata_r == value_r);

  always_comb begin
    count_nxt = count_r;
    if (cmd.push_wr) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_plus1;
    end
  end

  // Reads and writes only happen below the count, so the address fits.
  assign rd_addr = cmd.rd_next ? idx_plus1[IDX_W-1:0] : idx_r[IDX_W-1:0];
  // A push only happens below capacity, so the count fits the index width.
  assign wr_addr = cmd.push_wr ? count_r[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign wr_data = cmd.push_wr ? 32'(in_value) : rdata_r;
  assign wr_en   = cmd.push_wr | cmd.shift_wr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign pos_sel = cmd.hit ? idx_r[IDX_W-1:0] : pos_r;
  assign pos_ext = cmd.found ? 32'(pos_sel) : 32'd0;
  assign cnt_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= 32'(in_value);
    end
    if (cmd.hit) begin
      pos_r <= idx_r[IDX_W-1:0];
    end
    idx_r        <= idx_nxt;
    out_status_r <= cmd.status;
    out_found_r  <= cmd.found;
    out_pos_r    <= pos_ext[3:0];
    out_count_r  <= cnt_ext[4:0];
    out_empty_r  <= (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.report;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found          = out_found_r;
  assign out_match_position = out_pos_r;
  assign out_entry_count    = out_count_r;
  assign out_is_empty       = out_empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> !stat.full)
    else $error("push written into a full list");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dec |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("entry count did not drop by one");

endmodule

[rtl/bounded_list_with_erase.sv]
// ----------------------------------------------------------------------------
// bounded_list_with_erase
// Ordered list of up to CAPACITY signed 32-bit values with push, pop,
// erase-first-match and find.
// ----------------------------------------------------------------------------
// Usage:
//   An item (in_kind, in_value) is taken at a clock edge where start is high
//   and busy is low. Every item gives one result, shown on the out_ ports for
//   exactly one cycle with out_valid high; the receiver cannot stall it.
//   Push and pop finish in the accept cycle: out_valid rises in the next
//   cycle and busy never rises, so these items may be issued every cycle.
//   Find and erase step through the entry memory one word at a time, in a
//   read state and then a compare or move state. An erase scans up to the
//   match position p, then does one read and one write for each later
//   entry that moves down.
//   Reset clears the entry count, the result strobe and the sequencer
//   state; the memory keeps stale words, which are never read because all
//   accesses stay below the count.
// ----------------------------------------------------------------------------
module bounded_list_with_erase #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic [3:0]         out_match_position,
  output logic [4:0]         out_entry_count,
  output logic               out_is_empty
);

  blwe_pkg::dp_cmd_t  cmd;
  blwe_pkg::dp_stat_t stat;

  blwe_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (blwe_pkg::kind_t'(in_kind)),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  blwe_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_value           (in_value),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found          (out_found),
    .out_match_position (out_match_position),
    .out_entry_count    (out_entry_count),
    .out_is_empty       (out_is_empty)
  );

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted item neither reported nor in progress");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == blwe_pkg::ST_DONE))
    else $error("match reported with a failure status");

endmodule

[tb/list_op_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_op_checker
// Watches the command and result channels of the bounded list. It keeps its
// own copy of the list, works out the reply to every accepted item and
// compares each strobed result, field by field, with the oldest reply due.
// ----------------------------------------------------------------------------
module list_op_checker #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_value,
  input  logic               out_valid,
  input  logic [1:0]         out_status,
  input  logic               out_found,
  input  logic [3:0]         out_match_position,
  input  logic [4:0]         out_entry_count,
  input  logic               out_is_empty,
  output int                 fail_count,
  output int                 replies_due
);

  typedef struct packed {
    blwe_pkg::status_t status;
    logic              found;
    logic [3:0]        position;
    logic [4:0]        count;
    logic              empty;
  } list_reply_t;

  logic signed [31:0] shadow_words [CAPACITY];
  int unsigned        shadow_count;
  list_reply_t        reply_queue [$];

  initial begin
    fail_count   = 0;
    replies_due  = 0;
    shadow_count = 0;
  end

  // Applies one item to the shadow list and returns the reply it causes.
  function automatic list_reply_t apply_list_op(input blwe_pkg::kind_t kind,
                                                input logic signed [31:0] value);
    list_reply_t reply;
    int unsigned hit;
    reply.status   = blwe_pkg::ST_DONE;
    reply.found    = 1'b0;
    reply.position = 4'd0;
    case (kind)
      blwe_pkg::KIND_PUSH: begin
        if (shadow_count >= CAPACITY) begin
          reply.status = blwe_pkg::ST_FULL;
        end else begin
          shadow_words[shadow_count] = value;
          shadow_count++;
        end
      end
      blwe_pkg::KIND_POP: begin
        if (shadow_count == 0) reply.status = blwe_pkg::ST_EMPTY;
        else shadow_count--;
      end
      default: begin
        hit = shadow_count;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_words[i] == value) begin
            hit = i;
            break;
          end
        end
        if (hit >= shadow_count) begin
          reply.status = blwe_pkg::ST_MISSING;
        end else begin
          reply.found    = 1'b1;
          reply.position = hit[3:0];
          if (kind == blwe_pkg::KIND_ERASE) begin
            for (int unsigned i = hit; i + 1 < shadow_count; i++)
              shadow_words[i] = shadow_words[i + 1];
            shadow_count--;
          end
        end
      end
    endcase
    reply.count = shadow_count[4:0];
    reply.empty = (shadow_count == 0);
    return reply;
  endfunction

  function automatic int field_errors(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    list_reply_t want;
    int          errors;
    if (!rst_n) begin
      shadow_count = 0;
      reply_queue.delete();
    end else begin
      // A result strobed at this edge belongs to an item taken earlier, so it
      // is checked before the item taken at this edge is predicted.
      if (out_valid !== 1'b0) begin
        if (reply_queue.size() == 0) begin
          $display("%0t: result with none due, expected nothing, actual status %0h",
                   $time, out_status);
          fail_count++;
        end else begin
          want = reply_queue.pop_front();
          errors = field_errors("status", want.status, out_status)
                 + field_errors("found", want.found, out_found)
                 + field_errors("match_position", want.position, out_match_position)
                 + field_errors("entry_count", want.count, out_entry_count)
                 + field_errors("is_empty", want.empty, out_is_empty);
          if (errors != 0) fail_count++;
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        reply_queue.push_back(apply_list_op(blwe_pkg::kind_t'(in_kind), in_value));
    end
    replies_due = reply_queue.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the bounded list with a directed opening and then random pushes,
// pops, erases and finds whose mix swings the list between empty and full,
// under several sender idle patterns, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int CAPACITY     = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
  localparam int PHASE_ITEMS  = 238;
  localparam int BLOCK_ITEMS  = 40;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               start    = 1'b0;
  logic [1:0]         in_kind  = blwe_pkg::KIND_PUSH;
  logic signed [31:0] in_value = '0;
  logic               busy;
  logic               out_valid;
  logic [1:0]         out_status;
  logic               out_found;
  logic [3:0]         out_match_position;
  logic [4:0]         out_entry_count;
  logic               out_is_empty;

  int fail_count;
  int replies_due;
  int cycle_count = 0;
  int idle_pct    = 0;
  int push_pct    = 50;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bounded_list_with_erase #(.CAPACITY(CAPACITY)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found          (out_found),
    .out_match_position (out_match_position),
    .out_entry_count    (out_entry_count),
    .out_is_empty       (out_is_empty)
  );

  list_op_checker #(.CAPACITY(CAPACITY)) list_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found          (out_found),
    .out_match_position (out_match_position),
    .out_entry_count    (out_entry_count),
    .out_is_empty       (out_is_empty),
    .fail_count         (fail_count),
    .replies_due        (replies_due)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Presents one item after a random idle stretch and holds it until taken.
  task automatic send_item(input blwe_pkg::kind_t kind, input logic signed [31:0] value);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start    <= 1'b0;
      in_kind  <= 2'($urandom_range(3));
      in_value <= $urandom;
    end
    @(negedge clk);
    start    <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Mostly a small pool of values so that finds and erases hit, often twice.
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(99) < 40) return $urandom;
    case ($urandom_range(7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom_range(5);
    endcase
  endfunction

  function automatic blwe_pkg::kind_t pick_kind();
    if ($urandom_range(99) < push_pct) return blwe_pkg::KIND_PUSH;
    case ($urandom_range(2))
      0: return blwe_pkg::KIND_POP;
      1: return blwe_pkg::KIND_ERASE;
      default: return blwe_pkg::KIND_FIND;
    endcase
  endfunction

  initial begin : stimulus
    int phase_idle [4];
    int block_push [4];
    logic signed [31:0] fill;
    phase_idle = '{0, 57, 0, 8};
    block_push = '{25, 50, 75, 95};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Operations on an empty list.
    send_item(blwe_pkg::KIND_POP, 32'sd0);
    send_item(blwe_pkg::KIND_FIND, 32'sd0);
    send_item(blwe_pkg::KIND_ERASE, 32'sh7FFF_FFFF);
    // Fill to capacity with extremes and duplicates, then push once more.
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) fill = 32'sh7FFF_FFFF;
      else if (i == 1) fill = 32'sh8000_0000;
      else if (i == CAPACITY - 1) fill = 32'sh5A5A_A5A5;
      else fill = i % 4;
      send_item(blwe_pkg::KIND_PUSH, fill);
    end
    send_item(blwe_pkg::KIND_PUSH, 32'sd9);
    send_item(blwe_pkg::KIND_FIND, 32'sh5A5A_A5A5);
    send_item(blwe_pkg::KIND_FIND, 32'sd2);
    send_item(blwe_pkg::KIND_FIND, 32'sd12345);
    send_item(blwe_pkg::KIND_ERASE, 32'sd1);
    send_item(blwe_pkg::KIND_ERASE, 32'sh5A5A_A5A5);
    send_item(blwe_pkg::KIND_ERASE, 32'sh7FFF_FFFF);
    send_item(blwe_pkg::KIND_ERASE, 32'sd12345);
    send_item(blwe_pkg::KIND_POP, 32'sd0);

    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % BLOCK_ITEMS == 0) push_pct = block_push[$urandom_range(3)];
        send_item(pick_kind(), pick_value());
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait (replies_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && replies_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
